// ----- src/mandelbrot_escape_time_assert.svh -----
// Assertion macros for the escape-time block.
// Both macros sample on i_clk and are off while i_rst_n is low.
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// Same-cycle implication.
`define MBET_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MBET_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mbet_pkg.sv -----
package mbet_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int MAX_SIZE    = 20000;
    localparam int ITER_CAP    = 1000;

    localparam int SIZE_W      = 15;
    localparam int ITER_W      = 10;
    localparam int GRAY_W      = 8;

    localparam int FX_W        = FRAC_BITS + 4;
    localparam int SUM_W       = FRAC_BITS + 8;
    localparam int PROD_W      = 2 * FX_W;
    localparam int Q_W         = FRAC_BITS + 2;

    localparam int DIV_STEP    = 3;
    localparam int DIV_STAGES  = (Q_W + DIV_STEP - 1) / DIV_STEP;

    localparam int RING_STAGES = 3;
    localparam int TAG_W       = $clog2(RING_STAGES);

    localparam int SIZE_CAP_I  = (MAX_SIZE < 2**SIZE_W) ? MAX_SIZE : 2**SIZE_W - 1;

    typedef logic        [SIZE_W-1:0] t_size;
    typedef logic        [ITER_W-1:0] t_iter;
    typedef logic        [TAG_W-1:0]  t_tag;
    typedef logic signed [FX_W-1:0]   t_fx;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_size SIZE_CAP   = SIZE_CAP_I[SIZE_W-1:0];
    localparam t_size SIZE_ONE   = t_size'(1);
    localparam t_iter ITER_LIMIT = ITER_CAP[ITER_W-1:0];
    localparam t_fx   FX_TWO     = {4'b0010, {FRAC_BITS{1'b0}}};
    localparam t_sum  SUM_FOUR   = {8'b0000_0100, {FRAC_BITS{1'b0}}};

    typedef enum logic {
        CFG_IMAGE_SIZE = 1'b0,
        CFG_MAX_ITER   = 1'b1
    } t_cfg_reg;

    // Mapped point handed from the coordinate pipeline to the iteration loop.
    typedef struct packed {
        logic valid;
        logic outside;
        t_fx  cr;
        t_fx  ci;
    } t_coord;

    typedef struct packed {
        logic              strobe;
        logic [GRAY_W-1:0] gray;
        logic              escaped;
    } t_result;

endpackage

// ----- src/mbet_coord.sv -----
module mbet_coord (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  mbet_pkg::t_size        i_column,
    input  mbet_pkg::t_size        i_row,
    input  mbet_pkg::t_size        i_size,
    input  logic                   i_take,
    output logic                   o_ready,
    output mbet_pkg::t_coord       o_coord
);

    typedef struct packed {
        logic                      valid;
        logic                      outside;
        mbet_pkg::t_size           rem_c;
        mbet_pkg::t_size           rem_r;
        logic [mbet_pkg::Q_W-1:0]  quo_c;
        logic [mbet_pkg::Q_W-1:0]  quo_r;
    } t_div;

    t_div r_stage [mbet_pkg::DIV_STAGES];
    t_div n_stage [mbet_pkg::DIV_STAGES];
    logic w_hold;

    // One restoring step: double the remainder, subtract the size if it fits.
    function automatic logic [mbet_pkg::SIZE_W:0] div_step(
        input mbet_pkg::t_size rem,
        input mbet_pkg::t_size size
    );
        logic [mbet_pkg::SIZE_W:0] dbl;
        logic [mbet_pkg::SIZE_W:0] diff;
        dbl  = {rem, 1'b0};
        diff = dbl - {1'b0, size};
        if (dbl >= {1'b0, size}) begin
            div_step = {diff[mbet_pkg::SIZE_W-1:0], 1'b1};
        end else begin
            div_step = {dbl[mbet_pkg::SIZE_W-1:0], 1'b0};
        end
    endfunction

    // Freeze the whole pipe while the loop cannot take the oldest point.
    assign w_hold  = r_stage[mbet_pkg::DIV_STAGES-1].valid && !i_take;
    assign o_ready = !w_hold;

    for (genvar s = 0; s < mbet_pkg::DIV_STAGES; s++) begin : g_stage
        localparam int FIRST = s * mbet_pkg::DIV_STEP;
        localparam int NSTEP = (mbet_pkg::Q_W - FIRST < mbet_pkg::DIV_STEP) ?
                               mbet_pkg::Q_W - FIRST : mbet_pkg::DIV_STEP;

        t_div w_src;

        if (s == 0) begin : g_first
            always_comb begin
                w_src.valid   = i_valid;
                w_src.outside = (i_column >= i_size) || (i_row >= i_size);
                w_src.rem_c   = i_column;
                w_src.rem_r   = i_row;
                w_src.quo_c   = '0;
                w_src.quo_r   = '0;
            end
        end else begin : g_next
            assign w_src = r_stage[s-1];
        end

        always_comb begin
            t_div                      v;
            logic [mbet_pkg::SIZE_W:0] st_c;
            logic [mbet_pkg::SIZE_W:0] st_r;
            v = w_src;
            for (int j = 0; j < NSTEP; j++) begin
                st_c    = div_step(v.rem_c, i_size);
                st_r    = div_step(v.rem_r, i_size);
                v.rem_c = st_c[mbet_pkg::SIZE_W:1];
                v.rem_r = st_r[mbet_pkg::SIZE_W:1];
                v.quo_c = {v.quo_c[mbet_pkg::Q_W-2:0], st_c[0]};
                v.quo_r = {v.quo_r[mbet_pkg::Q_W-2:0], st_r[0]};
            end
            n_stage[s] = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < mbet_pkg::DIV_STAGES; s++) begin
                r_stage[s].valid <= 1'b0;
            end
        end else if (!w_hold) begin
            for (int s = 0; s < mbet_pkg::DIV_STAGES; s++) begin
                r_stage[s] <= n_stage[s];
            end
        end
    end

    // Quotient lies in [0, 4); shift the origin to -2.
    assign o_coord.valid   = r_stage[mbet_pkg::DIV_STAGES-1].valid;
    assign o_coord.outside = r_stage[mbet_pkg::DIV_STAGES-1].outside;
    assign o_coord.cr      = {2'b00, r_stage[mbet_pkg::DIV_STAGES-1].quo_c} - mbet_pkg::FX_TWO;
    assign o_coord.ci      = {2'b00, r_stage[mbet_pkg::DIV_STAGES-1].quo_r} - mbet_pkg::FX_TWO;

endmodule

// ----- src/mbet_ring.sv -----
module mbet_ring (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbet_pkg::t_coord  i_coord,
    input  mbet_pkg::t_iter   i_limit,
    output logic              o_take,
    output mbet_pkg::t_result o_result
);

    typedef struct packed {
        logic                          valid;
        logic                          done;
        mbet_pkg::t_tag                tag;
        mbet_pkg::t_iter               step;
        logic [mbet_pkg::GRAY_W-1:0]   gray;
        logic                          escaped;
        mbet_pkg::t_fx                 cr;
        mbet_pkg::t_fx                 ci;
    } t_ctl;

    typedef struct packed {
        t_ctl          ctl;
        mbet_pkg::t_fx zr;
        mbet_pkg::t_fx zi;
    } t_stage_a;

    typedef struct packed {
        t_ctl            ctl;
        mbet_pkg::t_prod p_rr;
        mbet_pkg::t_prod p_ii;
        mbet_pkg::t_prod p_ri;
    } t_stage_b;

    typedef struct packed {
        t_ctl           ctl;
        mbet_pkg::t_sum mag;
        mbet_pkg::t_sum diff;
        mbet_pkg::t_sum dbl;
    } t_stage_c;

    t_stage_a          r_a, n_a;
    t_stage_b          r_b, n_b;
    t_stage_c          r_c, n_c;
    mbet_pkg::t_tag    r_tag_in, n_tag_in;
    mbet_pkg::t_tag    r_head, n_head;
    mbet_pkg::t_result r_out, n_out;

    // Products of the current z.
    always_comb begin
        n_b.ctl  = r_a.ctl;
        n_b.p_rr = r_a.zr * r_a.zr;
        n_b.p_ii = r_a.zi * r_a.zi;
        n_b.p_ri = r_a.zr * r_a.zi;
    end

    // Scale back (floor) and form |z|^2, the real part and twice the cross term.
    always_comb begin
        mbet_pkg::t_sum sq_rr;
        mbet_pkg::t_sum sq_ii;
        mbet_pkg::t_sum sq_ri;
        sq_rr    = r_b.p_rr[mbet_pkg::FRAC_BITS +: mbet_pkg::SUM_W];
        sq_ii    = r_b.p_ii[mbet_pkg::FRAC_BITS +: mbet_pkg::SUM_W];
        sq_ri    = r_b.p_ri[mbet_pkg::FRAC_BITS +: mbet_pkg::SUM_W];
        n_c.ctl  = r_b.ctl;
        n_c.mag  = sq_rr + sq_ii;
        n_c.diff = sq_rr - sq_ii;
        n_c.dbl  = {sq_ri[mbet_pkg::SUM_W-2:0], 1'b0};
    end

    // Close the loop: retire the oldest finished pixel, refill free slots,
    // test for escape and advance z.
    always_comb begin
        logic            retire;
        logic            free;
        mbet_pkg::t_sum  nr;
        mbet_pkg::t_sum  ni;
        mbet_pkg::t_iter step_m1;

        retire  = r_c.ctl.valid && r_c.ctl.done && (r_c.ctl.tag == r_head);
        free    = !r_c.ctl.valid || retire;
        o_take  = free && i_coord.valid;

        n_out.strobe  = retire;
        n_out.gray    = r_c.ctl.gray;
        n_out.escaped = r_c.ctl.escaped;

        n_head   = r_head + mbet_pkg::t_tag'(retire);
        n_tag_in = r_tag_in + mbet_pkg::t_tag'(o_take);

        nr      = r_c.diff + mbet_pkg::t_sum'(r_c.ctl.cr);
        ni      = r_c.dbl + mbet_pkg::t_sum'(r_c.ctl.ci);
        step_m1 = r_c.ctl.step - mbet_pkg::t_iter'(1);

        n_a.ctl = r_c.ctl;
        n_a.zr  = nr[mbet_pkg::FX_W-1:0];
        n_a.zi  = ni[mbet_pkg::FX_W-1:0];

        if (free) begin
            n_a.ctl.valid   = i_coord.valid;
            n_a.ctl.done    = i_coord.outside;
            n_a.ctl.tag     = r_tag_in;
            n_a.ctl.step    = '0;
            n_a.ctl.gray    = '0;
            n_a.ctl.escaped = 1'b0;
            n_a.ctl.cr      = i_coord.cr;
            n_a.ctl.ci      = i_coord.ci;
            n_a.zr          = '0;
            n_a.zi          = '0;
        end else if (!r_c.ctl.done) begin
            if (r_c.mag >= mbet_pkg::SUM_FOUR) begin
                n_a.ctl.done    = 1'b1;
                n_a.ctl.escaped = 1'b1;
                n_a.ctl.gray    = {step_m1[mbet_pkg::GRAY_W-2:0], 1'b0};
            end else if (r_c.ctl.step == i_limit) begin
                n_a.ctl.done    = 1'b1;
                n_a.ctl.escaped = 1'b0;
                n_a.ctl.gray    = '0;
            end else begin
                n_a.ctl.step    = r_c.ctl.step + mbet_pkg::t_iter'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.ctl.valid <= 1'b0;
            r_b.ctl.valid <= 1'b0;
            r_c.ctl.valid <= 1'b0;
            r_tag_in      <= '0;
            r_head        <= '0;
            r_out.strobe  <= 1'b0;
        end else begin
            r_a      <= n_a;
            r_b      <= n_b;
            r_c      <= n_c;
            r_tag_in <= n_tag_in;
            r_head   <= n_head;
            r_out    <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

// ----- src/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time pixel engine.
// Request channel: drive start high with i_column and i_row; the request is
// taken at the rising edge where start is high and busy is low. Hold the
// request while busy is high.
// Result channel: o_gray and o_escaped are valid for the single cycle in
// which o_strobe is high; results come back in request order and cannot be
// held off by the receiver.
// Configuration: i_cfg_we with i_cfg_addr (0 image size, 1 step limit) and
// i_cfg_wdata writes a register at once; write only while no request is open.
// Flow: a 10-stage pipelined divider maps the pixel to c, then a three-stage
// loop (multiply, sum, update) runs one z step per lap around its stages and
// holds up to three pixels at once, so new requests enter while older pixels
// iterate. A pixel outside the image skips the z steps, and any result waits
// behind older pixels.
// busy rises when the loop has no free slot for the oldest mapped point.
// Reset (synchronous, active low) empties both pipes and loads image size 512
// and step limit 256. No clearing pass is needed.
`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [14:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [14:0] i_column,
    input  logic [14:0] i_row,
    output logic        o_strobe,
    output logic [7:0]  o_gray,
    output logic        o_escaped
);

    mbet_pkg::t_size   r_image_size;
    mbet_pkg::t_iter   r_max_iter;
    mbet_pkg::t_size   w_size;
    mbet_pkg::t_iter   w_limit;
    mbet_pkg::t_coord  w_coord;
    mbet_pkg::t_result w_result;
    logic              w_ready;
    logic              w_take;

    // Decode configuration writes; an unlisted index cannot occur on a 1-bit address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= mbet_pkg::t_size'(512);
            r_max_iter   <= mbet_pkg::t_iter'(256);
        end else if (i_cfg_we) begin
            unique case (mbet_pkg::t_cfg_reg'(i_cfg_addr))
                mbet_pkg::CFG_IMAGE_SIZE: r_image_size <= i_cfg_wdata;
                mbet_pkg::CFG_MAX_ITER:   r_max_iter   <= i_cfg_wdata[mbet_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the registers to their working ranges: size zero acts as one,
    // size past the cap acts as the cap, and a zero or oversized limit
    // falls back to the step cap.
    always_comb begin
        if (r_image_size == '0) begin
            w_size = mbet_pkg::SIZE_ONE;
        end else if (r_image_size > mbet_pkg::SIZE_CAP) begin
            w_size = mbet_pkg::SIZE_CAP;
        end else begin
            w_size = r_image_size;
        end

        if (r_max_iter == '0 || r_max_iter > mbet_pkg::ITER_LIMIT) begin
            w_limit = mbet_pkg::ITER_LIMIT;
        end else begin
            w_limit = r_max_iter;
        end
    end

    // Hold new requests off while the coordinate pipe is frozen.
    assign busy = !w_ready;

    mbet_coord u_coord (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_column (i_column),
        .i_row    (i_row),
        .i_size   (w_size),
        .i_take   (w_take),
        .o_ready  (w_ready),
        .o_coord  (w_coord)
    );

    mbet_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coord  (w_coord),
        .i_limit  (w_limit),
        .o_take   (w_take),
        .o_result (w_result)
    );

    assign o_strobe  = w_result.strobe;
    assign o_gray    = w_result.gray;
    assign o_escaped = w_result.escaped;

    // A pixel that never escaped reports gray zero.
    `MBET_ASSERT_NOW(a_no_escape_gray, o_strobe && !o_escaped, o_gray == 8'd0, "gray set without escape")
    // Gray is twice the escape step less one, wrapped to eight bits, and so always even.
    `MBET_ASSERT_NOW(a_gray_even, o_strobe && o_escaped, !o_gray[0], "odd gray on escape")
    // A mapped point the loop did not take stays put for the next cycle.
    `MBET_ASSERT_NEXT(a_coord_hold, w_coord.valid && !w_take, w_coord.valid && $stable(w_coord.cr) && $stable(w_coord.ci), "mapped point lost while loop full")

endmodule
